FILE: hdl/fat_pkg.sv
// Shared types and constants for the truncating float32 adder.
`timescale 1ns / 1ps
package fat_pkg;
  localparam int unsigned ExpW = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned MantW = 27;
  localparam logic [4:0] MaxShift = 5'b11111;
  localparam logic [4:0] LzNone = 5'd26;

  // Stage 1 to stage 2: aligned operands.
  typedef struct packed {
    logic             pass;
    logic [31:0]      pass_word;
    logic             sub;
    logic [MantW-1:0] big;
    logic [MantW-1:0] aligned;
    logic [ExpW-1:0]  ebig;
    logic             sign;
  } fat_align_t;

  // Stage 2 to stage 3: raw sum after carry fix.
  typedef struct packed {
    logic             pass;
    logic [31:0]      pass_word;
    logic [25:0]      norm;
    logic [ExpW-1:0]  enorm;
    logic             sign;
  } fat_sum_t;

  // Count leading zeros of a 26-bit word; 26 when zero.
  function automatic logic [4:0] lz26(input logic [25:0] v);
    logic [4:0] n;
    logic       found;
    n = LzNone;
    found = 1'b0;
    for (int b = 25; b >= 0; b--) begin
      if (!found && v[b]) begin
        n = 5'(25 - b);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage

FILE: hdl/fat_align.sv
// Stage 1: operand compare, swap and mantissa alignment.
`timescale 1ns / 1ps
module fat_align import fat_pkg::*; (
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output fat_align_t  align_o
);
  logic [ExpW-1:0]  ea, eb;
  logic [23:0]      ma, mb, small_m;
  logic [ExpW-1:0]  dabs;
  logic [4:0]       diff;
  logic             pick_b, same_mag;
  logic [MantW-1:0] small_sh;

  always_comb begin
    ea = operand_a_i[30:23];
    eb = operand_b_i[30:23];
    ma = {1'b1, operand_a_i[22:0]};
    mb = {1'b1, operand_b_i[22:0]};
    dabs = (ea > eb) ? ea - eb : eb - ea;
    diff = (dabs > 8'(MaxShift)) ? MaxShift : dabs[4:0];
    pick_b = (dabs == '0) ? !(ma > mb) : !(ea > eb);
    same_mag = (dabs == '0) && (ma == mb);
    small_m = pick_b ? ma : mb;
    small_sh = {1'b0, small_m, 2'b00};
    align_o.pass = (ea == '0) || (eb == '0);
    align_o.pass_word = (ea == '0) ? operand_b_i : operand_a_i;
    align_o.sub = operand_a_i[31] ^ operand_b_i[31];
    align_o.big = {1'b0, (pick_b ? mb : ma), 2'b00};
    align_o.aligned = small_sh >> diff;
    align_o.ebig = pick_b ? eb : ea;
    align_o.sign = same_mag ? (operand_a_i[31] & operand_b_i[31])
                            : (pick_b ? operand_b_i[31] : operand_a_i[31]);
  end
endmodule

FILE: hdl/fat_norm.sv
// Stage 3: leading-zero normalize and pack the result word.
`timescale 1ns / 1ps
module fat_norm import fat_pkg::*; (
  input  fat_sum_t    sum_i,
  output logic [31:0] word_o
);
  logic [4:0]  lz;
  logic [25:0] shifted;
  logic        ok;

  always_comb begin
    lz = lz26(sum_i.norm);
    shifted = sum_i.norm << lz;
    ok = sum_i.enorm > 8'(lz);
    if (sum_i.pass) begin
      word_o = sum_i.pass_word;
    end else begin
      word_o = {sum_i.sign,
                (ok && lz != LzNone) ? sum_i.enorm - 8'(lz) : 8'd0,
                ok ? shifted[24:2] : 23'd0};
    end
  end
endmodule

FILE: hdl/float32_adder_truncating_unit.sv
// Top level of the truncating float32 adder: three-stage pipeline.
// The done strobe travels with the word through the align, sum and output registers.
// Throughput: one word per cycle; busy is tied low.
// Stages: align, add, normalize into the output register.
// Reset clears the valid bits only; data registers are not reset.
`timescale 1ns / 1ps
module float32_adder_truncating_unit import fat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done,
  output logic [31:0] sum_bits_o
);
  fat_align_t  al_d, al_q;
  fat_sum_t    sm_d, sm_q;
  logic [31:0] w_d, w_q;
  logic [2:0]  v_q;
  logic [MantW-1:0] raw;

  assign busy = 1'b0;

  fat_align u_align (.operand_a_i(operand_a_i), .operand_b_i(operand_b_i), .align_o(al_d));

  // Add or subtract aligned mantissas, fix carry.
  always_comb begin
    raw = al_q.sub ? al_q.big - al_q.aligned : al_q.big + al_q.aligned;
    sm_d.pass = al_q.pass;
    sm_d.pass_word = al_q.pass_word;
    sm_d.sign = al_q.sign;
    sm_d.norm = raw[26] ? raw[26:1] : raw[25:0];
    sm_d.enorm = raw[26] ? al_q.ebig + 8'd1 : al_q.ebig;
  end

  fat_norm u_norm (.sum_i(sm_q), .word_o(w_d));

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], start};
    end
  end

  // Advance data.
  always_ff @(posedge clk_i) begin
    al_q <= al_d;
    sm_q <= sm_d;
    w_q  <= w_d;
  end

  assign done = v_q[2];
  assign sum_bits_o = w_q;

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##3 done) else $error("word lost in pipeline");
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(v_q[1])) else $error("done without source word");
  a_busy: assert property (@(posedge clk_i) !busy) else $error("busy raised");
`endif
endmodule
